>>> rtl/rfd_pkg.sv
// Shared types and constants of the RPC frame deframer.
`timescale 1ns / 1ps

package rfd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned TDATA_W    = 48;
	localparam int unsigned TUSER_W    = 3;

	localparam logic [WORD_W-1:0] FRAME_OVERHEAD = 32'd26;
	localparam logic [WORD_W-1:0] WORD_BYTES     = 32'd4;
	localparam logic [WORD_W-1:0] MIN_FRAME_LEN  = 32'd5;
	localparam logic [WORD_W-1:0] END_OFFSET     = 32'd2;

	localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd2;
	localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MARKER = 1'b0,
		REG_END_MARKER   = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_HUNT  = 4'd0,
		PH_LEN   = 4'd1,
		PH_IDLEN = 4'd2,
		PH_ID    = 4'd3,
		PH_MLEN  = 4'd4,
		PH_METH  = 4'd5,
		PH_ECODE = 4'd6,
		PH_ELEN  = 4'd7,
		PH_ETEXT = 4'd8,
		PH_PAY   = 4'd9,
		PH_CSUM  = 4'd10,
		PH_ENDB  = 4'd11
	} phase_t;

	typedef enum logic [2:0] {
		KIND_MSG_ID = 3'd0,
		KIND_METHOD = 3'd1,
		KIND_ETEXT  = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_DONE   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_GOOD    = 2'd0,
		STAT_BAD_END = 2'd1,
		STAT_OVERRUN = 2'd2
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic [WORD_W-1:0] error_word;
		status_t           status;
		logic              last;
	} result_t;

endpackage

>>> rtl/rfd_core.sv
// Frame walker: parser state and per-byte next-state and result logic.
`timescale 1ns / 1ps

module rfd_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [rfd_pkg::BYTE_W-1:0] in_byte,
	input  logic [rfd_pkg::BYTE_W-1:0] start_marker,
	input  logic [rfd_pkg::BYTE_W-1:0] end_marker,
	output rfd_pkg::result_t       res
);
	import rfd_pkg::*;

	typedef struct packed {
		phase_t            phase;
		logic [WORD_W-1:0] cnt;
	} lf_t;

	// next field after a finished data field, skipping empty ones
	function automatic lf_t leave_field(phase_t ph, logic ovr, logic [WORD_W-1:0] budget);
		lf_t r;
		r.phase = PH_ENDB;
		r.cnt   = '0;
		unique case (ph)
			PH_ID: begin
				r.phase = PH_MLEN;
				r.cnt   = WORD_BYTES;
			end
			PH_METH: begin
				r.phase = PH_ECODE;
				r.cnt   = WORD_BYTES;
			end
			PH_ETEXT: begin
				if (ovr || budget == '0) begin
					r.phase = PH_CSUM;
					r.cnt   = WORD_BYTES;
				end else begin
					r.phase = PH_PAY;
					r.cnt   = budget;
				end
			end
			PH_PAY: begin
				r.phase = PH_CSUM;
				r.cnt   = WORD_BYTES;
			end
			default: begin
				r.phase = PH_ENDB;
				r.cnt   = '0;
			end
		endcase
		return r;
	endfunction

	phase_t            phase_q, phase_d;
	logic [WORD_W-1:0] cnt_q, cnt_d;
	logic [WORD_W-1:0] ws_q, ws_d;
	logic [WORD_W-1:0] budget_q, budget_d;   // frame length - overhead - lengths so far
	logic [WORD_W-1:0] last_q, last_d;       // position of the end byte minus one
	logic [WORD_W-1:0] pos_q, pos_d;
	logic [WORD_W-1:0] err_q, err_d;
	logic              ovr_q, ovr_d;

	logic [WORD_W-1:0] word_d;
	logic [WORD_W-1:0] cnt_dec;
	logic [WORD_W-1:0] budget_sub;
	logic              len_ovr;
	phase_t            data_ph;
	lf_t               lf;

	assign word_d     = {ws_q[WORD_W-BYTE_W-1:0], in_byte};
	assign cnt_dec    = cnt_q - 1'b1;
	assign budget_sub = budget_q - word_d;
	assign len_ovr    = word_d > budget_q;

	always_comb begin
		unique case (phase_q)
			PH_IDLEN: data_ph = PH_ID;
			PH_MLEN:  data_ph = PH_METH;
			default:  data_ph = PH_ETEXT;
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		ws_d     = ws_q;
		budget_d = budget_q;
		last_d   = last_q;
		pos_d    = pos_q;
		err_d    = err_q;
		ovr_d    = ovr_q;
		res      = '0;
		lf       = '0;
		if (accept) begin
			if (phase_q == PH_HUNT) begin
				if (in_byte == start_marker) begin
					pos_d   = '0;
					err_d   = '0;
					ovr_d   = 1'b0;
					phase_d = PH_LEN;
					cnt_d   = WORD_BYTES;
				end
			end else begin
				pos_d = pos_q + 1'b1;
				if (phase_q != PH_LEN && pos_q == last_q) begin
					res.valid      = 1'b1;
					res.kind       = KIND_DONE;
					res.error_word = err_q;
					res.last       = 1'b1;
					if (ovr_q || phase_q != PH_ENDB)
						res.status = STAT_OVERRUN;
					else if (in_byte != end_marker)
						res.status = STAT_BAD_END;
					else
						res.status = STAT_GOOD;
					phase_d = PH_HUNT;
				end else begin
					unique case (phase_q)
						PH_LEN, PH_IDLEN, PH_MLEN, PH_ECODE, PH_ELEN: begin
							ws_d  = word_d;
							cnt_d = cnt_dec;
							if (cnt_dec == '0) begin
								if (phase_q == PH_LEN) begin
									last_d   = word_d - END_OFFSET;
									budget_d = word_d - FRAME_OVERHEAD;
									ovr_d    = word_d < FRAME_OVERHEAD;
									if (word_d <= MIN_FRAME_LEN) begin
										res.valid      = 1'b1;
										res.kind       = KIND_DONE;
										res.error_word = err_q;
										res.status     = STAT_OVERRUN;
										res.last       = 1'b1;
										phase_d        = PH_HUNT;
									end else begin
										phase_d = PH_IDLEN;
										cnt_d   = WORD_BYTES;
									end
								end else if (phase_q == PH_ECODE) begin
									err_d   = word_d;
									phase_d = PH_ELEN;
									cnt_d   = WORD_BYTES;
								end else begin
									ovr_d    = ovr_q | len_ovr;
									budget_d = budget_sub;
									phase_d  = data_ph;
									cnt_d    = word_d;
									if (word_d == '0) begin
										lf      = leave_field(data_ph, ovr_q | len_ovr, budget_sub);
										phase_d = lf.phase;
										cnt_d   = lf.cnt;
									end
								end
							end
						end
						PH_ID, PH_METH, PH_ETEXT, PH_PAY: begin
							res.valid = 1'b1;
							res.data  = in_byte;
							unique case (phase_q)
								PH_ID:    res.kind = KIND_MSG_ID;
								PH_METH:  res.kind = KIND_METHOD;
								PH_ETEXT: res.kind = KIND_ETEXT;
								default:  res.kind = KIND_PAYLOAD;
							endcase
							cnt_d = cnt_dec;
							if (cnt_dec == '0) begin
								lf      = leave_field(phase_q, ovr_q, budget_q);
								phase_d = lf.phase;
								cnt_d   = lf.cnt;
							end
						end
						PH_CSUM: begin
							cnt_d = cnt_dec;
							if (cnt_dec == '0)
								phase_d = PH_ENDB;
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_q    <= '0;
			ws_q     <= '0;
			budget_q <= '0;
			last_q   <= '0;
			pos_q    <= '0;
			err_q    <= '0;
			ovr_q    <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			ws_q     <= ws_d;
			budget_q <= budget_d;
			last_q   <= last_d;
			pos_q    <= pos_d;
			err_q    <= err_d;
			ovr_q    <= ovr_d;
		end
	end

endmodule

>>> rtl/rpc_frame_deframer.sv
// Top level of the RPC frame deframer: config registers, parser and output register.
`timescale 1ns / 1ps

// Takes one received byte per clock and emits at most one result per byte: each
// message id, method name, error text and payload byte tagged by kind in tuser,
// and a done transfer (tlast) carrying error code and status at the frame's end
// byte, or at the last length byte if the length is too short. The parser state
// updates in the cycle a byte is accepted and the result lands in a single output
// register; s_tready drops only while that register holds a result that m_tready
// is not taking, so the sustained rate is one byte per clock. Marker registers are
// written through the cfg channel, which is always ready.
module rpc_frame_deframer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [rfd_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rfd_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [39:8] error_word,
	                                                 // [41:40] frame_status, [47:42] zero
	output logic [rfd_pkg::TUSER_W-1:0]   m_tuser,   // [2:0] field_kind
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rfd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfd_pkg::BYTE_W-1:0]    cfg_data
);
	import rfd_pkg::*;

	logic [BYTE_W-1:0] start_marker_q;
	logic [BYTE_W-1:0] end_marker_q;
	logic              in_xfer;
	result_t           res;
	result_t           out_q;
	logic              out_valid_q;

	assign cfg_ready = 1'b1;
	assign s_tready  = !out_valid_q || m_tready;
	assign in_xfer   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RESET;
			end_marker_q   <= END_MARKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
			endcase
		end
	end

	rfd_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_xfer),
		.in_byte      (s_tdata),
		.start_marker (start_marker_q),
		.end_marker   (end_marker_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= res.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && res.valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-BYTE_W-WORD_W-2){1'b0}}, out_q.status,
		out_q.error_word, out_q.data};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

endmodule

>>> rtl/rfd_checker.sv
// Port-level checks of the RPC frame deframer and their bind.
`timescale 1ns / 1ps

module rfd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rfd_pkg::TDATA_W-1:0]   m_tdata,
	input logic [rfd_pkg::TUSER_W-1:0]   m_tuser,
	input logic                          m_tlast
);
	import rfd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled output changed");

	// input backpressure only while the output register is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// tlast marks exactly the done transfers
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == KIND_DONE)))
		else $error("tlast and kind disagree");

	// field bytes carry no status or error code
	a_field_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[TDATA_W-1:BYTE_W] == '0)
		else $error("field transfer with nonzero status or error");

	// done transfers carry a zero byte and a defined status
	a_done_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[BYTE_W-1:0] == '0
		&& m_tdata[BYTE_W+WORD_W+1:BYTE_W+WORD_W] != 2'd3)
		else $error("malformed done transfer");

endmodule

bind rpc_frame_deframer rfd_checker u_rfd_checker (.*);
